// ===== rtl/itcv_pkg.sv =====
// Package for the IPv4/TCP checksum verifier: frame-kind codes, protocol constants
// and the structs that carry a frame verdict down the result pipeline.
// Depends on nothing.
`timescale 1ns / 1ps

package itcv_pkg;

	localparam logic [15:0] POS_MAX   = 16'hffff;
	localparam logic [15:0] TYPE_IPV4 = 16'h0800;
	localparam logic [15:0] TYPE_ARP  = 16'h0806;
	localparam logic [15:0] LLC_LIMIT = 16'd1500;
	localparam logic [15:0] ETH_HDR   = 16'd14;
	localparam logic [15:0] MIN_IPV4  = 16'd18;
	localparam logic [7:0]  PROTO_TCP = 8'd6;
	localparam logic [3:0]  IHL_MIN   = 4'd5;
	localparam logic [3:0]  IHL_MASK  = 4'd15;

	typedef enum logic [1:0] {
		KIND_LLC   = 2'd0,
		KIND_IPV4  = 2'd1,
		KIND_ARP   = 2'd2,
		KIND_OTHER = 2'd3
	} frame_kind_t;

	// Per-frame state as it stands after the final byte.
	typedef struct packed {
		logic [15:0] type_field;
		logic [3:0]  header_words;
		logic [15:0] total_length;
		logic [7:0]  protocol;
		logic [20:0] hdr_acc;
		logic [31:0] seg_acc;
		logic [15:0] hdr_stored;
		logic [15:0] seg_stored;
		logic [15:0] count;
	} snap_t;

	// Classified frame with the first fold of the header sum done.
	typedef struct packed {
		frame_kind_t kind;
		logic        ip_chk;
		logic        tcp_chk;
		logic        trunc;
		logic        hbad;
		logic [16:0] hdr_fold;
		logic [31:0] seg_sum;
		logic [15:0] hdr_stored;
		logic [15:0] seg_stored;
	} class_t;

	typedef struct packed {
		frame_kind_t kind;
		logic        ip_checked;
		logic        ip_sum_ok;
		logic [15:0] ip_sum_calc;
		logic        tcp_checked;
		logic        tcp_sum_ok;
		logic [15:0] tcp_sum_calc;
		logic        truncated;
		logic        header_bad;
	} verdict_t;

endpackage

// ===== rtl/ipv4_tcp_checksum_verifier.sv =====
// Top level of the IPv4/TCP checksum verifier: byte intake, per-frame sums and
// the verdict pipeline. Depends on itcv_pkg.
`timescale 1ns / 1ps

// The block takes one Ethernet frame byte per clock on the frame channel and
// produces one verdict transfer per frame, after the final byte has passed
// the input, snapshot, classify and output registers. Every byte goes through
// an input register and then a single update of the running sums (one 21-bit
// and one 32-bit add), so a frame streams at one byte per cycle with no gaps
// between frames. The final byte hands a snapshot of the sums to a verdict
// pipeline of three registers (classify, first fold, final fold and compare).
// frame_ready falls only when a final byte sits in the input register while
// that pipeline is full and the verdict output is stalled; ordinary bytes
// never wait. After reset and after every final byte all per-frame state is
// zero, and bytes past position 65534 are not examined.
module ipv4_tcp_checksum_verifier (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  frame_valid,
	output logic                  frame_ready,
	input  logic [7:0]            frame_byte,
	input  logic                  frame_last,
	output logic                  verdict_valid,
	input  logic                  verdict_ready,
	output logic [1:0]            frame_kind,
	output logic                  ip_checked,
	output logic                  ip_sum_ok,
	output logic [15:0]           ip_sum_calc,
	output logic                  tcp_checked,
	output logic                  tcp_sum_ok,
	output logic [15:0]           tcp_sum_calc,
	output logic                  truncated,
	output logic                  header_bad
);
	import itcv_pkg::*;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Per-frame state.
	logic [15:0] pos_q;
	logic [15:0] type_q;
	logic [3:0]  hw_q;
	logic [15:0] tl_q;
	logic [7:0]  proto_q;
	logic [20:0] hacc_q;
	logic [31:0] sacc_q;
	logic [7:0]  pend_q;
	logic [15:0] hsum_q;
	logic [15:0] ssum_q;

	// Verdict pipeline.
	logic     valid_s2;
	snap_t    snap_s2;
	logic     valid_s3;
	class_t   cls_s3;
	logic     out_valid_q;
	verdict_t res_q;

	// Handshake chain: each stage may load when it is empty or its content moves on.
	logic out_free, s3_ready, s2_ready, s1_go;

	assign out_free    = !out_valid_q || verdict_ready;
	assign s3_ready    = !valid_s3 || out_free;
	assign s2_ready    = !valid_s2 || s3_ready;
	assign s1_go       = valid_s1 && (!last_s1 || s2_ready);
	assign frame_ready = !valid_s1 || !last_s1 || s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_ready) begin
			valid_s1 <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_valid && frame_ready) begin
			byte_s1 <= frame_byte;
			last_s1 <= frame_last;
		end
	end

	// Per-byte update. The byte at position pos_q is examined with the type field
	// and header length already updated by this same byte, as the framing needs.
	logic [15:0] idx;
	logic        upd, ipv4_on, in_hdr, in_seg, seg_add;
	logic [15:0] type_n, tl_n, rel, seg_start, seg_r, word;
	logic [16:0] seg_end;
	logic [3:0]  hw_n;
	logic [5:0]  hlen_n;
	logic [7:0]  proto_n, pend_n;
	logic [15:0] hsum_n, ssum_n;
	logic [20:0] hacc_n;
	logic [31:0] sacc_n;
	logic [15:0] pos_n;

	assign idx = pos_q;
	assign upd = (pos_q != POS_MAX);

	always_comb begin
		type_n  = type_q;
		hw_n    = hw_q;
		tl_n    = tl_q;
		proto_n = proto_q;
		pend_n  = pend_q;
		hsum_n  = hsum_q;
		ssum_n  = ssum_q;
		hacc_n  = hacc_q;
		sacc_n  = sacc_q;
		pos_n   = upd ? pos_q + 16'd1 : pos_q;

		if (upd && idx == 16'd12) begin
			type_n = {byte_s1, 8'h00};
		end
		if (upd && idx == 16'd13) begin
			type_n = {type_q[15:8], byte_s1};
		end
		ipv4_on = upd && (type_n == TYPE_IPV4) && (idx >= ETH_HDR);

		if (ipv4_on && idx == 16'd14) begin
			hw_n = byte_s1[3:0] & IHL_MASK;
		end
		if (ipv4_on && idx == 16'd16) begin
			tl_n = {byte_s1, 8'h00};
		end
		if (ipv4_on && idx == 16'd17) begin
			tl_n = {tl_q[15:8], byte_s1};
		end
		if (ipv4_on && idx == 16'd23) begin
			proto_n = byte_s1;
		end

		hlen_n    = {hw_n, 2'b00};
		rel       = idx - ETH_HDR;
		word      = idx[0] ? {8'h00, byte_s1} : {byte_s1, 8'h00};
		seg_start = ETH_HDR + {10'd0, hlen_n};
		seg_end   = {1'b0, ETH_HDR} + {1'b0, tl_n};
		seg_r     = idx - seg_start;

		in_hdr = ipv4_on && (rel < {10'd0, hlen_n});
		in_seg = ipv4_on && (hlen_n >= 6'd20) && (idx >= seg_start)
			&& ({1'b0, idx} < seg_end);

		if (in_hdr) begin
			if (idx == 16'd24) begin
				pend_n = byte_s1;
			end else if (idx == 16'd25) begin
				hsum_n = {pend_q, byte_s1};
			end else begin
				hacc_n = hacc_q + {5'd0, word};
			end
		end

		// The segment starts at byte 34 or later, so the address words (bytes
		// 26 to 33) and segment bytes never share one cycle.
		seg_add = ipv4_on && (idx >= 16'd26) && (idx <= 16'd33);
		if (in_seg) begin
			if (seg_r == 16'd16) begin
				pend_n = byte_s1;
			end else if (seg_r == 16'd17) begin
				ssum_n = {pend_q, byte_s1};
			end else begin
				seg_add = 1'b1;
			end
		end
		if (seg_add) begin
			sacc_n = sacc_q + {16'd0, word};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			type_q  <= '0;
			hw_q    <= '0;
			tl_q    <= '0;
			proto_q <= '0;
			hacc_q  <= '0;
			sacc_q  <= '0;
			pend_q  <= '0;
			hsum_q  <= '0;
			ssum_q  <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				pos_q   <= '0;
				type_q  <= '0;
				hw_q    <= '0;
				tl_q    <= '0;
				proto_q <= '0;
				hacc_q  <= '0;
				sacc_q  <= '0;
				pend_q  <= '0;
				hsum_q  <= '0;
				ssum_q  <= '0;
			end else begin
				pos_q   <= pos_n;
				type_q  <= type_n;
				hw_q    <= hw_n;
				tl_q    <= tl_n;
				proto_q <= proto_n;
				hacc_q  <= hacc_n;
				sacc_q  <= sacc_n;
				pend_q  <= pend_n;
				hsum_q  <= hsum_n;
				ssum_q  <= ssum_n;
			end
		end
	end

	// Snapshot of the finished frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= s1_go && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && s1_go && last_s1) begin
			snap_s2.type_field   <= type_n;
			snap_s2.header_words <= hw_n;
			snap_s2.total_length <= tl_n;
			snap_s2.protocol     <= proto_n;
			snap_s2.hdr_acc      <= hacc_n;
			snap_s2.seg_acc      <= sacc_n;
			snap_s2.hdr_stored   <= hsum_n;
			snap_s2.seg_stored   <= ssum_n;
			snap_s2.count        <= pos_n;
		end
	end

	// Classification, length checks, pseudo-header add and first header fold.
	class_t      cls_n;
	logic [5:0]  hlen_v;
	logic [16:0] cnt17, hdr_end, seg_end_v;
	logic [15:0] tcp_len;
	logic        long_enough, is_tcp;

	always_comb begin
		hlen_v      = {snap_s2.header_words, 2'b00};
		cnt17       = {1'b0, snap_s2.count};
		hdr_end     = {1'b0, ETH_HDR} + {11'd0, hlen_v};
		seg_end_v   = {1'b0, ETH_HDR} + {1'b0, snap_s2.total_length};
		long_enough = (snap_s2.count >= MIN_IPV4);
		is_tcp      = (snap_s2.protocol == PROTO_TCP);
		tcp_len     = snap_s2.total_length - {10'd0, hlen_v};

		if (snap_s2.type_field < LLC_LIMIT) begin
			cls_n.kind = KIND_LLC;
		end else if (snap_s2.type_field == TYPE_IPV4) begin
			cls_n.kind = KIND_IPV4;
		end else if (snap_s2.type_field == TYPE_ARP) begin
			cls_n.kind = KIND_ARP;
		end else begin
			cls_n.kind = KIND_OTHER;
		end

		cls_n.hbad = long_enough && ((snap_s2.header_words < IHL_MIN)
			|| (snap_s2.total_length < {10'd0, hlen_v}));
		cls_n.trunc = !long_enough || (cnt17 < hdr_end)
			|| (!cls_n.hbad && is_tcp && (cnt17 < seg_end_v));
		cls_n.ip_chk  = long_enough && !cls_n.hbad && (cnt17 >= hdr_end);
		cls_n.tcp_chk = cls_n.ip_chk && is_tcp && (cnt17 >= seg_end_v);

		// Every field but the kind means nothing outside IPv4.
		if (cls_n.kind != KIND_IPV4) begin
			cls_n.hbad    = 1'b0;
			cls_n.trunc   = 1'b0;
			cls_n.ip_chk  = 1'b0;
			cls_n.tcp_chk = 1'b0;
		end

		cls_n.hdr_fold   = {1'b0, snap_s2.hdr_acc[15:0]} + {12'd0, snap_s2.hdr_acc[20:16]};
		cls_n.seg_sum    = snap_s2.seg_acc + {24'd0, snap_s2.protocol} + {16'd0, tcp_len};
		cls_n.hdr_stored = snap_s2.hdr_stored;
		cls_n.seg_stored = snap_s2.seg_stored;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_ready) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_ready && valid_s2) begin
			cls_s3 <= cls_n;
		end
	end

	// End-around carry folds, inversion and comparison with the stored sums.
	verdict_t    res_n;
	logic [15:0] hdr_f2, seg_f2, hdr_calc, seg_calc;
	logic [16:0] seg_f1;

	always_comb begin
		hdr_f2   = cls_s3.hdr_fold[15:0] + {15'd0, cls_s3.hdr_fold[16]};
		seg_f1   = {1'b0, cls_s3.seg_sum[15:0]} + {1'b0, cls_s3.seg_sum[31:16]};
		seg_f2   = seg_f1[15:0] + {15'd0, seg_f1[16]};
		hdr_calc = ~hdr_f2;
		seg_calc = ~seg_f2;

		res_n.kind         = cls_s3.kind;
		res_n.ip_checked   = cls_s3.ip_chk;
		res_n.ip_sum_ok    = cls_s3.ip_chk && (hdr_calc == cls_s3.hdr_stored);
		res_n.ip_sum_calc  = cls_s3.ip_chk ? hdr_calc : 16'd0;
		res_n.tcp_checked  = cls_s3.tcp_chk;
		res_n.tcp_sum_ok   = cls_s3.tcp_chk && (seg_calc == cls_s3.seg_stored);
		res_n.tcp_sum_calc = cls_s3.tcp_chk ? seg_calc : 16'd0;
		res_n.truncated    = cls_s3.trunc;
		res_n.header_bad   = cls_s3.hbad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s3) begin
			res_q <= res_n;
		end
	end

	assign verdict_valid = out_valid_q;
	assign frame_kind    = res_q.kind;
	assign ip_checked    = res_q.ip_checked;
	assign ip_sum_ok     = res_q.ip_sum_ok;
	assign ip_sum_calc   = res_q.ip_sum_calc;
	assign tcp_checked   = res_q.tcp_checked;
	assign tcp_sum_ok    = res_q.tcp_sum_ok;
	assign tcp_sum_calc  = res_q.tcp_sum_calc;
	assign truncated     = res_q.truncated;
	assign header_bad    = res_q.header_bad;

	// A TCP check is only ever reported together with a header check.
	assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> (!tcp_checked || ip_checked))
		else $error("tcp_checked without ip_checked");

	// A bad header is never also reported as checked.
	assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> !(header_bad && ip_checked))
		else $error("header_bad together with ip_checked");

	// Outside IPv4 every flag of the verdict stays clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		(verdict_valid && frame_kind != KIND_IPV4) |->
		(!ip_checked && !tcp_checked && !truncated && !header_bad))
		else $error("IPv4 flags set on a non-IPv4 frame");

	// The transfer of a final byte leaves the per-frame state cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_s1) |=> (pos_q == 16'd0 && hacc_q == 21'd0 && sacc_q == 32'd0))
		else $error("per-frame state not cleared after final byte");

endmodule

// ===== tb/ipv4_tcp_checksum_verifier_test.sv =====
// Self-checking testbench for the IPv4/TCP checksum verifier: builds Ethernet frames,
// streams them byte by byte and checks every verdict against its own frame model.
// Depends on itcv_pkg and ipv4_tcp_checksum_verifier.
`timescale 1ns / 1ps

module ipv4_tcp_checksum_verifier_test;
	import itcv_pkg::*;

	// Byte offsets inside an Ethernet frame, counted from the destination MAC.
	localparam int OFS_TYPE     = 12;
	localparam int OFS_IHL      = 14;
	localparam int OFS_TOTAL    = 16;
	localparam int OFS_PROTO    = 23;
	localparam int OFS_HDR_CSUM = 24;
	localparam int OFS_ADDR     = 26;
	localparam int ADDR_BYTES   = 8;
	// Offset of the checksum word inside a TCP segment, and the bytes it needs.
	localparam int TCP_CSUM_OFS = 16;
	localparam int TCP_CSUM_END = 18;
	localparam int IPV4_MIN_HDR = 20;
	localparam int NO_FLIP      = -1;
	localparam int PROTO_UDP    = 17;

	localparam int RANDOM_BYTES = 700;
	// Settling time after the last expected verdict has been checked.
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 1000000;

	// Receiver stall patterns. Each one lasts for a random stretch of cycles.
	typedef enum int {
		RX_OPEN,
		RX_ALTERNATE,
		RX_SPARSE,
		RX_RUNS
	} rx_mode_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        frame_valid   = 1'b0;
	logic        frame_ready;
	logic [7:0]  frame_byte    = 8'h00;
	logic        frame_last    = 1'b0;
	logic        verdict_valid;
	logic        verdict_ready = 1'b0;
	logic [1:0]  frame_kind;
	logic        ip_checked;
	logic        ip_sum_ok;
	logic [15:0] ip_sum_calc;
	logic        tcp_checked;
	logic        tcp_sum_ok;
	logic [15:0] tcp_sum_calc;
	logic        truncated;
	logic        header_bad;

	ipv4_tcp_checksum_verifier dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame_byte   (frame_byte),
		.frame_last   (frame_last),
		.verdict_valid(verdict_valid),
		.verdict_ready(verdict_ready),
		.frame_kind   (frame_kind),
		.ip_checked   (ip_checked),
		.ip_sum_ok    (ip_sum_ok),
		.ip_sum_calc  (ip_sum_calc),
		.tcp_checked  (tcp_checked),
		.tcp_sum_ok   (tcp_sum_ok),
		.tcp_sum_calc (tcp_sum_calc),
		.truncated    (truncated),
		.header_bad   (header_bad)
	);

	// 4 ns clock period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Frame model. It follows every accepted byte and keeps the per-frame
	// state that the block itself keeps: position, type, IHL, total length,
	// protocol, the two running sums and the two received checksums.
	// ------------------------------------------------------------------
	logic [15:0] pos_count    = '0;
	logic [15:0] eth_type     = '0;
	logic [3:0]  ip_ihl       = '0;
	logic [15:0] ip_total_len = '0;
	logic [7:0]  ip_proto     = '0;
	logic [20:0] hdr_sum      = '0;
	logic [31:0] seg_sum      = '0;
	logic [7:0]  held_byte    = '0;
	logic [15:0] hdr_csum_rx  = '0;
	logic [15:0] seg_csum_rx  = '0;

	// Verdicts that the model has worked out and the block has not yet sent.
	verdict_t expected_verdicts[$];
	bit       failed = 1'b0;

	// End-around carry fold of a 32-bit sum, then the ones' complement.
	function automatic logic [15:0] fold_complement(input logic [31:0] s);
		logic [31:0] t;
		t = s[15:0] + s[31:16];
		t = t[15:0] + t[31:16];
		return ~t[15:0];
	endfunction

	function automatic void clear_frame();
		pos_count    = '0;
		eth_type     = '0;
		ip_ihl       = '0;
		ip_total_len = '0;
		ip_proto     = '0;
		hdr_sum      = '0;
		seg_sum      = '0;
		held_byte    = '0;
		hdr_csum_rx  = '0;
		seg_csum_rx  = '0;
	endfunction

	// Folds one frame byte at position idx into the running state.
	function automatic void absorb_byte(input int unsigned idx, input logic [7:0] b);
		int unsigned hl, rel, w, seg0, seg_end;
		if (idx == OFS_TYPE) eth_type = {b, 8'h00};
		if (idx == OFS_TYPE + 1) eth_type = eth_type | b;
		if (eth_type != TYPE_IPV4 || idx < ETH_HDR) return;
		if (idx == OFS_IHL) ip_ihl = b[3:0] & IHL_MASK;
		if (idx == OFS_TOTAL) ip_total_len = {b, 8'h00};
		if (idx == OFS_TOTAL + 1) ip_total_len = ip_total_len | b;
		if (idx == OFS_PROTO) ip_proto = b;
		hl = ip_ihl * 4;
		rel = idx - ETH_HDR;
		// Even offsets from the IP header carry the high byte of a word.
		w = rel[0] ? b : {b, 8'h00};
		if (rel < hl) begin
			if (idx == OFS_HDR_CSUM) held_byte = b;
			else if (idx == OFS_HDR_CSUM + 1) hdr_csum_rx = {held_byte, b};
			else hdr_sum = 21'(hdr_sum + w);
		end
		// Source and destination addresses go into the TCP pseudo-header.
		if (idx >= OFS_ADDR && idx < OFS_ADDR + ADDR_BYTES) seg_sum = seg_sum + w;
		seg0 = ETH_HDR + hl;
		seg_end = ETH_HDR + ip_total_len;
		if (hl >= IPV4_MIN_HDR && idx >= seg0 && idx < seg_end) begin
			if (idx - seg0 == TCP_CSUM_OFS) held_byte = b;
			else if (idx - seg0 == TCP_CSUM_OFS + 1) seg_csum_rx = {held_byte, b};
			else seg_sum = seg_sum + w;
		end
	endfunction

	// Works out the verdict for the frame that just ended and starts a new one.
	function automatic void close_frame();
		verdict_t    v;
		int unsigned cnt, hl, hdr_end, seg_end, s;
		logic        hbad, trunc, ipchk, tcpchk;
		v = '0;
		if (eth_type < LLC_LIMIT) v.kind = KIND_LLC;
		else if (eth_type == TYPE_IPV4) v.kind = KIND_IPV4;
		else if (eth_type == TYPE_ARP) v.kind = KIND_ARP;
		else v.kind = KIND_OTHER;
		if (v.kind == KIND_IPV4) begin
			cnt = pos_count;
			hl = ip_ihl * 4;
			hdr_end = ETH_HDR + hl;
			seg_end = ETH_HDR + ip_total_len;
			hbad = cnt >= MIN_IPV4 && (ip_ihl < IHL_MIN || ip_total_len < hl);
			trunc = cnt < MIN_IPV4 || cnt < hdr_end ||
				(!hbad && ip_proto == PROTO_TCP && cnt < seg_end);
			ipchk = cnt >= MIN_IPV4 && !hbad && cnt >= hdr_end;
			tcpchk = ipchk && ip_proto == PROTO_TCP && cnt >= seg_end;
			if (ipchk) begin
				v.ip_checked = 1'b1;
				v.ip_sum_calc = fold_complement({11'd0, hdr_sum});
				v.ip_sum_ok = v.ip_sum_calc == hdr_csum_rx;
			end
			if (tcpchk) begin
				s = seg_sum + ip_proto + (ip_total_len - hl);
				v.tcp_checked = 1'b1;
				v.tcp_sum_calc = fold_complement(s);
				v.tcp_sum_ok = v.tcp_sum_calc == seg_csum_rx;
			end
			v.truncated = trunc;
			v.header_bad = hbad;
		end
		expected_verdicts.push_back(v);
		clear_frame();
	endfunction

	function automatic void compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, want, got);
			failed = 1'b1;
		end
	endfunction

	// Both sides are sampled at the rising edge: first the byte transfer feeds
	// the model, then a verdict transfer is checked against the oldest
	// expectation. A verdict cannot leave in the cycle of its own final byte,
	// so the order of the two does not matter for correctness.
	always @(posedge clk) begin
		verdict_t want, seen;
		if (arst_n) begin
			if (frame_valid && frame_ready) begin
				if (pos_count < POS_MAX) begin
					absorb_byte(pos_count, frame_byte);
					pos_count = pos_count + 1'b1;
				end
				if (frame_last) close_frame();
			end
			if (verdict_valid && verdict_ready) begin
				seen.kind         = frame_kind_t'(frame_kind);
				seen.ip_checked   = ip_checked;
				seen.ip_sum_ok    = ip_sum_ok;
				seen.ip_sum_calc  = ip_sum_calc;
				seen.tcp_checked  = tcp_checked;
				seen.tcp_sum_ok   = tcp_sum_ok;
				seen.tcp_sum_calc = tcp_sum_calc;
				seen.truncated    = truncated;
				seen.header_bad   = header_bad;
				if (expected_verdicts.size() == 0) begin
					$display("%0t ns: verdict transfer with no frame pending, kind 0x%0h",
						$time, frame_kind);
					failed = 1'b1;
				end else begin
					want = expected_verdicts.pop_front();
					compare_field("frame_kind", want.kind, seen.kind);
					compare_field("ip_checked", want.ip_checked, seen.ip_checked);
					compare_field("ip_sum_ok", want.ip_sum_ok, seen.ip_sum_ok);
					compare_field("ip_sum_calc", want.ip_sum_calc, seen.ip_sum_calc);
					compare_field("tcp_checked", want.tcp_checked, seen.tcp_checked);
					compare_field("tcp_sum_ok", want.tcp_sum_ok, seen.tcp_sum_ok);
					compare_field("tcp_sum_calc", want.tcp_sum_calc, seen.tcp_sum_calc);
					compare_field("truncated", want.truncated, seen.truncated);
					compare_field("header_bad", want.header_bad, seen.header_bad);
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	int cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Verdict receiver. It changes ready at the falling edge and switches
	// between stall patterns at random. A long hold-off requested by a test
	// is counted down here, in cycles, before any pattern resumes.
	// ------------------------------------------------------------------
	int       hold_request = 0;
	int       hold_left    = 0;
	int       mode_left    = 0;
	int       run_left     = 0;
	bit       run_high     = 1'b1;
	rx_mode_t rx_mode      = RX_OPEN;

	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			verdict_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			case (rx_mode)
				RX_OPEN: verdict_ready <= 1'b1;
				RX_ALTERNATE: verdict_ready <= ~verdict_ready;
				RX_SPARSE: verdict_ready <= $urandom_range(0, 9) >= 3;
				default: begin
					// Alternating runs of ready and of stall, each of random length.
					if (run_left == 0) begin
						run_high = ~run_high;
						run_left = $urandom_range(1, 12);
					end
					run_left--;
					verdict_ready <= run_high;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Frame sender. Bytes go out in bursts of random length with random
	// gaps between them, so gaps can land on any byte position of a frame,
	// final bytes included. With steady set, bytes go out back to back.
	// ------------------------------------------------------------------
	logic [7:0] frame_buf[];
	int         burst_left = 0;
	bit         steady     = 1'b0;

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (!steady && burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				frame_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		if (burst_left > 0) burst_left--;
		@(negedge clk);
		frame_valid <= 1'b1;
		frame_byte <= b;
		frame_last <= last;
		@(posedge clk);
		while (!frame_ready) @(posedge clk);
	endtask

	// Valid stays high between back-to-back transfers; it must be lowered
	// before the sender lets clock edges pass with nothing to offer.
	task automatic sender_idle();
		@(negedge clk);
		frame_valid <= 1'b0;
	endtask

	task automatic send_frame();
		foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	// ------------------------------------------------------------------
	// Frame builders. They work on frame_buf and write only bytes that
	// exist, so the same calls also build frames cut short.
	// ------------------------------------------------------------------
	function automatic void put_byte(input int pos, input logic [7:0] v);
		if (pos < frame_buf.size()) frame_buf[pos] = v;
	endfunction

	function automatic void put_word(input int pos, input int unsigned v);
		put_byte(pos, 8'(v >> 8));
		put_byte(pos + 1, 8'(v));
	endfunction

	function automatic void fill_random(input int len);
		frame_buf = new[len];
		foreach (frame_buf[i]) frame_buf[i] = 8'($urandom);
	endfunction

	// Sum of big-endian words over [from, to), leaving out the word at skip.
	function automatic int unsigned word_sum(input int from, input int to, input int skip);
		int unsigned acc;
		acc = 0;
		for (int i = from; i < to; i++) begin
			if (i != skip && i != skip + 1)
				acc += ((i - from) % 2 == 0) ? {frame_buf[i], 8'h00} : {8'h00, frame_buf[i]};
		end
		return acc;
	endfunction

	// Writes correct header and TCP checksums wherever the frame holds the
	// whole header, and the whole segment for TCP.
	function automatic void seal_sums();
		int unsigned hl, total, s;
		if (frame_buf.size() <= OFS_PROTO) return;
		hl = frame_buf[OFS_IHL][3:0] * 4;
		total = {frame_buf[OFS_TOTAL], frame_buf[OFS_TOTAL + 1]};
		if (hl < IPV4_MIN_HDR || frame_buf.size() < ETH_HDR + hl) return;
		put_word(OFS_HDR_CSUM,
			fold_complement(word_sum(ETH_HDR, ETH_HDR + hl, OFS_HDR_CSUM)));
		if (frame_buf[OFS_PROTO] != PROTO_TCP || total < hl + TCP_CSUM_END ||
				frame_buf.size() < ETH_HDR + total)
			return;
		s = word_sum(OFS_ADDR, OFS_ADDR + ADDR_BYTES, NO_FLIP) + PROTO_TCP + (total - hl) +
			word_sum(ETH_HDR + hl, ETH_HDR + total, ETH_HDR + hl + TCP_CSUM_OFS);
		put_word(ETH_HDR + hl + TCP_CSUM_OFS, fold_complement(s));
	endfunction

	// Builds and sends an IPv4 frame of len bytes. A random version nibble
	// sits above the IHL. With seal set the checksums are made correct; a
	// bit of byte flip_at is then inverted to break one of them.
	task automatic ipv4_frame(input int len, input int ihl, input int total, input int proto,
			input bit seal, input int flip_at);
		fill_random(len);
		put_word(OFS_TYPE, TYPE_IPV4);
		put_byte(OFS_IHL, {4'($urandom), 4'(ihl)});
		put_word(OFS_TOTAL, total);
		put_byte(OFS_PROTO, 8'(proto));
		if (seal) seal_sums();
		if (flip_at != NO_FLIP && flip_at < len)
			frame_buf[flip_at] = frame_buf[flip_at] ^ (8'h01 << $urandom_range(0, 7));
		send_frame();
	endtask

	task automatic typed_frame(input int len, input int unsigned eth_kind);
		fill_random(len);
		put_word(OFS_TYPE, eth_kind);
		send_frame();
	endtask

	task automatic flat_frame(input int len, input logic [7:0] v);
		frame_buf = new[len];
		foreach (frame_buf[i]) frame_buf[i] = v;
		send_frame();
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Type field classes, including both sides of the LLC limit, and the
	// all-zero and all-one byte extremes.
	task automatic check_frame_kinds();
		flat_frame(64, 8'h00);
		flat_frame(64, 8'hff);
		typed_frame(60, LLC_LIMIT - 1);
		typed_frame(60, LLC_LIMIT);
		typed_frame(42, TYPE_ARP);
	endtask

	// Frames that end before or inside the type field or the IPv4 header.
	task automatic check_short_frames();
		fill_random(1);
		send_frame();
		// Only the high type byte arrives; the missing low byte reads as zero.
		fill_random(OFS_TYPE + 1);
		put_byte(OFS_TYPE, 8'(TYPE_IPV4 >> 8));
		send_frame();
		ipv4_frame(14, 5, 40, PROTO_TCP, 1'b0, NO_FLIP);
		ipv4_frame(17, 5, 40, PROTO_TCP, 1'b0, NO_FLIP);
		ipv4_frame(18, 5, 40, PROTO_UDP, 1'b0, NO_FLIP);
		ipv4_frame(30, 5, 40, PROTO_TCP, 1'b0, NO_FLIP);
	endtask

	// IHL below five and total length below the header length.
	task automatic check_bad_headers();
		ipv4_frame(40, 0, 40, PROTO_TCP, 1'b1, NO_FLIP);
		ipv4_frame(20, 4, 40, PROTO_TCP, 1'b1, NO_FLIP);
		ipv4_frame(60, 5, 10, PROTO_TCP, 1'b1, NO_FLIP);
		ipv4_frame(80, 15, 59, PROTO_TCP, 1'b1, NO_FLIP);
	endtask

	// Header checksums for a non-TCP protocol: good, damaged, with options,
	// and a frame cut inside a maximum-length header.
	task automatic check_ip_header_sums();
		ipv4_frame(46, 5, 32, PROTO_UDP, 1'b1, NO_FLIP);
		ipv4_frame(46, 5, 32, PROTO_UDP, 1'b1, OFS_PROTO - 1);
		ipv4_frame(82, 15, 68, PROTO_UDP, 1'b1, NO_FLIP);
		ipv4_frame(82, 15, 68, PROTO_UDP, 1'b1, OFS_HDR_CSUM);
		ipv4_frame(40, 15, 80, PROTO_UDP, 1'b1, NO_FLIP);
	endtask

	// TCP segments: even and odd lengths, padding, damage, a segment too
	// short to hold its checksum, an empty one, a cut one and IP options.
	task automatic check_tcp_segments();
		ipv4_frame(54, 5, 40, PROTO_TCP, 1'b1, NO_FLIP);
		ipv4_frame(65, 5, 45, PROTO_TCP, 1'b1, NO_FLIP);
		ipv4_frame(74, 5, 60, PROTO_TCP, 1'b1, 40);
		ipv4_frame(44, 5, 30, PROTO_TCP, 1'b1, NO_FLIP);
		ipv4_frame(34, 5, 20, PROTO_TCP, 1'b1, NO_FLIP);
		ipv4_frame(50, 5, 60, PROTO_TCP, 1'b1, NO_FLIP);
		ipv4_frame(72, 7, 58, PROTO_TCP, 1'b1, NO_FLIP);
	endtask

	// The receiver holds off for a long stretch while tiny frames keep
	// coming back to back, so the verdict pipeline fills and the block has
	// to lower frame_ready on a final byte.
	task automatic check_output_backpressure();
		hold_request = 300;
		steady = 1'b1;
		repeat (40) begin
			fill_random($urandom_range(1, 3));
			send_frame();
		end
		steady = 1'b0;
	endtask

	// Mostly well-formed IPv4 traffic with correct sums and random content,
	// some of it damaged; the rest is broken IPv4 and non-IPv4 noise.
	task automatic check_random_traffic();
		int bytes_sent, pick, ihl, seg, len, total, proto;
		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
				seg = $urandom_range(0, 48);
				proto = ($urandom_range(0, 3) != 0) ? PROTO_TCP : $urandom_range(0, 255);
				total = ihl * 4 + seg;
				len = ETH_HDR + total + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0);
				ipv4_frame(len, ihl, total, proto, 1'b1,
					($urandom_range(0, 4) == 0) ? $urandom_range(ETH_HDR, len - 1) : NO_FLIP);
			end else if (pick < 80) begin
				ihl = $urandom_range(0, 15);
				total = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) :
					$urandom_range(0, 100);
				proto = ($urandom_range(0, 1) == 0) ? PROTO_TCP : $urandom_range(0, 255);
				len = $urandom_range(1, 90);
				ipv4_frame(len, ihl, total, proto, 1'($urandom_range(0, 1)), NO_FLIP);
			end else begin
				len = $urandom_range(1, 80);
				fill_random(len);
				case ($urandom_range(0, 4))
					0: put_word(OFS_TYPE, $urandom_range(0, LLC_LIMIT - 1));
					1: put_word(OFS_TYPE, LLC_LIMIT);
					2: put_word(OFS_TYPE, TYPE_ARP);
					3: put_word(OFS_TYPE, $urandom_range(LLC_LIMIT, 65535));
					default: ;
				endcase
				send_frame();
			end
			bytes_sent += len;
		end
	endtask

	// Reset once, run the tests in turn, then let the last verdicts drain.
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		check_frame_kinds();
		check_short_frames();
		check_bad_headers();
		check_ip_header_sums();
		check_tcp_segments();
		check_output_backpressure();
		check_random_traffic();
		sender_idle();
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
